// ===== hdl/tvfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tvfs_pkg;

   localparam logic [7:0] SEP_BYTE  = 8'h5E;
   localparam logic [7:0] ESC_SEP   = 8'h5D;
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_FLAG  = 8'h7D;
   localparam logic [7:0] HDR_BYTE  = 8'hFD;
   localparam logic [7:0] BASE_LEN  = 8'h05;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] SEP_TRAIL = 8'h3E;
   localparam logic [7:0] ESC_TRAIL = 8'h3D;
   localparam logic [7:0] FLAG_TRAIL = 8'h5E;
   localparam logic [7:0] EFLAG_TRAIL = 8'h5D;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef struct packed {
      logic [7:0]      len_byte;
      logic [2:0][7:0] data;
      logic [2:0]      esc;
      logic [1:0]      pad_cnt;
   } frame_type;

   typedef enum logic [3:0] {
      ST_FLAG_OPEN,
      ST_HDR,
      ST_LEN,
      ST_ZERO,
      ST_SEP_OPEN,
      ST_DATA,
      ST_DATA_ESC,
      ST_SEP_CLOSE,
      ST_PAD,
      ST_FLAG_CLOSE
   } state_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == SEP_BYTE) || (b == ESC_SEP) || (b == FLAG_BYTE) || (b == ESC_FLAG);
   endfunction

   function automatic logic [7:0] esc_lead(input logic [7:0] b);
      return ((b == SEP_BYTE) || (b == ESC_SEP)) ? ESC_SEP : ESC_FLAG;
   endfunction

   function automatic logic [7:0] esc_trail(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         SEP_BYTE:  r = SEP_TRAIL;
         ESC_SEP:   r = ESC_TRAIL;
         FLAG_BYTE: r = FLAG_TRAIL;
         ESC_FLAG:  r = EFLAG_TRAIL;
         default:   r = b;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tvfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tvfs_front
   import tvfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [23:0] req_tdata,  // value_id [7:0], value_word [23:8]
   input  wire logic       req_tuser,   // high_first
   output logic            head_valid,
   output frame_type       head_frame,
   input  wire logic       head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   frame_type        entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [7:0] lo_byte, hi_byte, id_byte;
   logic       lo_esc, hi_esc;
   logic [1:0] esc_cnt;
   frame_type  classified;
   logic       push;

   // classify
   always_comb begin
      id_byte = req_tdata[7:0];
      lo_byte = req_tdata[15:8];
      hi_byte = req_tdata[23:16];
      lo_esc  = needs_escape(lo_byte);
      hi_esc  = needs_escape(hi_byte);
      esc_cnt = {1'b0, lo_esc} + {1'b0, hi_esc};
      classified.len_byte = BASE_LEN + {6'b0, esc_cnt};
      classified.pad_cnt  = 2'd2 - esc_cnt;
      classified.data[0]  = id_byte;
      classified.esc[0]   = needs_escape(id_byte);
      if (req_tuser) begin
         classified.data[1] = hi_byte;
         classified.esc[1]  = hi_esc;
         classified.data[2] = lo_byte;
         classified.esc[2]  = lo_esc;
      end else begin
         classified.data[1] = lo_byte;
         classified.esc[1]  = lo_esc;
         classified.data[2] = hi_byte;
         classified.esc[2]  = hi_esc;
      end
   end

   assign req_tready = (count_ff != CNT_FULL);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign head_frame = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, head_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tvfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tvfs_back
   import tvfs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire frame_type  head_frame,
   output logic            head_pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // line_byte
   output logic            rsp_tlast
);

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] pad_ff, pad_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       step;
   logic [7:0] cur_data;
   logic       cur_esc;
   logic [7:0] emit_byte;
   logic       emit_last;

   assign step     = head_valid && (!out_valid_ff || rsp_tready);
   assign cur_data = head_frame.data[idx_ff];
   assign cur_esc  = head_frame.esc[idx_ff];
   assign head_pop = step && (state_ff == ST_FLAG_CLOSE);

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      if (step) begin
         unique case (state_ff)
            ST_FLAG_OPEN: state_in = ST_HDR;
            ST_HDR:       state_in = ST_LEN;
            ST_LEN:       state_in = ST_ZERO;
            ST_ZERO:      state_in = ST_SEP_OPEN;
            ST_SEP_OPEN: begin
               state_in = ST_DATA;
               idx_in   = 2'd0;
            end
            ST_DATA: begin
               if (cur_esc) begin
                  state_in = ST_DATA_ESC;
               end else if (idx_ff == 2'd2) begin
                  state_in = ST_SEP_CLOSE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            ST_DATA_ESC: begin
               if (idx_ff == 2'd2) begin
                  state_in = ST_SEP_CLOSE;
               end else begin
                  state_in = ST_DATA;
                  idx_in   = idx_ff + 2'd1;
               end
            end
            ST_SEP_CLOSE: begin
               pad_in   = head_frame.pad_cnt;
               state_in = (head_frame.pad_cnt == 2'd0) ? ST_FLAG_CLOSE : ST_PAD;
            end
            ST_PAD: begin
               pad_in   = pad_ff - 2'd1;
               state_in = (pad_ff == 2'd1) ? ST_FLAG_CLOSE : ST_PAD;
            end
            ST_FLAG_CLOSE: state_in = ST_FLAG_OPEN;
            default:       state_in = ST_FLAG_OPEN;
         endcase
      end
   end

   // outputs
   always_comb begin
      emit_last = 1'b0;
      unique case (state_ff)
         ST_FLAG_OPEN: emit_byte = FLAG_BYTE;
         ST_HDR:       emit_byte = HDR_BYTE;
         ST_LEN:       emit_byte = head_frame.len_byte;
         ST_ZERO:      emit_byte = ZERO_BYTE;
         ST_SEP_OPEN:  emit_byte = SEP_BYTE;
         ST_DATA:      emit_byte = cur_esc ? esc_lead(cur_data) : cur_data;
         ST_DATA_ESC:  emit_byte = esc_trail(cur_data);
         ST_SEP_CLOSE: emit_byte = SEP_BYTE;
         ST_PAD:       emit_byte = ZERO_BYTE;
         ST_FLAG_CLOSE: begin
            emit_byte = FLAG_BYTE;
            emit_last = 1'b1;
         end
         default:      emit_byte = ZERO_BYTE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FLAG_OPEN;
         idx_ff       <= '0;
         pad_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pad_ff       <= pad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/telemetry_value_frame_stuffer_core.sv =====
// The first line byte of a frame passes through the queue entry, then the output register.
// Throughput: one line byte per cycle while a frame is queued and rsp_tready holds; a frame
// is 12 or 13 line bytes, set by the byte sequencer driving the single output register.
// The input queue holds QUEUE_DEPTH classified frames, so intake runs ahead of output.
// Reset (synchronous, active high) empties the queue, clears the output valid flag and
// returns the sequencer to the opening flag.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_value_frame_stuffer_core
   import tvfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // value_id [7:0], value_word [23:8]
   input  wire logic        req_tuser,  // high_first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // line_byte
   output logic             rsp_tlast   // frame_end
);

   logic      head_valid;
   frame_type head_frame;
   logic      head_pop;

   tvfs_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .head_pop   (head_pop)
   );

   tvfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== verif/tvfs_frame_checker.sv =====
`timescale 1ns / 1ps

module tvfs_frame_checker
   import tvfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,  // value_id [7:0], value_word [23:8]
   input  wire logic        req_tuser,  // high_first
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,  // line_byte
   input  wire logic        rsp_tlast,  // frame_end
   output int               fail_count,
   output int               pending_count,
   output int               bytes_checked
);

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_end;
   } line_beat_t;

   line_beat_t line_q[$];

   function automatic logic is_reserved_byte(input logic [7:0] b);
      return b inside {SEP_BYTE, ESC_SEP, FLAG_BYTE, ESC_FLAG};
   endfunction

   function automatic void push_line(input logic [7:0] b, input logic last_flag);
      line_beat_t beat;
      beat.line_byte = b;
      beat.frame_end = last_flag;
      line_q.push_back(beat);
   endfunction

   function automatic void push_stuffed(input logic [7:0] b);
      if (!is_reserved_byte(b)) begin
         push_line(b, 1'b0);
      end else begin
         // lead byte follows the class; trail flips bit 5 for flags, bits 6 and 5 for separators
         push_line((b[5] ? ESC_FLAG : ESC_SEP), 1'b0);
         push_line((b[5] ? (b ^ 8'h20) : (b ^ 8'h60)), 1'b0);
      end
   endfunction

   function automatic void predict_frame(input logic [7:0] value_id,
                                         input logic [15:0] value_word,
                                         input logic high_first);
      logic [7:0] lo_byte;
      logic [7:0] hi_byte;
      logic [1:0] esc_count;
      lo_byte   = value_word[7:0];
      hi_byte   = value_word[15:8];
      esc_count = 2'(is_reserved_byte(lo_byte)) + 2'(is_reserved_byte(hi_byte));
      push_line(FLAG_BYTE, 1'b0);
      push_line(HDR_BYTE, 1'b0);
      push_line(BASE_LEN + 8'(esc_count), 1'b0);
      push_line(ZERO_BYTE, 1'b0);
      push_line(SEP_BYTE, 1'b0);
      push_stuffed(value_id);
      push_stuffed(high_first ? hi_byte : lo_byte);
      push_stuffed(high_first ? lo_byte : hi_byte);
      push_line(SEP_BYTE, 1'b0);
      for (int i = esc_count; i < 2; i++) begin
         push_line(ZERO_BYTE, 1'b0);
      end
      push_line(FLAG_BYTE, 1'b1);
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      bytes_checked = 0;
   end

   always @(posedge clock) begin
      line_beat_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked <= bytes_checked + 1;
            if (line_q.size() == 0) begin
               $display("%0t: unexpected line byte, expected none, actual %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               want = line_q.pop_front();
               if (rsp_tdata !== want.line_byte || rsp_tlast !== want.frame_end) begin
                  $display("%0t: line byte mismatch, expected %02h last %0b, actual %02h last %0b",
                           $time, want.line_byte, want.frame_end, rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_frame(req_tdata[7:0], req_tdata[23:8], req_tuser);
         end
      end
      pending_count <= line_q.size();
   end

endmodule

// ===== verif/tb_telemetry_value_frame_stuffer_core.sv =====
`timescale 1ns / 1ps

module tb_telemetry_value_frame_stuffer_core
   import tvfs_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // value_id [7:0], value_word [23:8]
   logic        req_tuser  = 1'b0;  // high_first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;  // line_byte
   logic        rsp_tlast;  // frame_end

   int fail_count;
   int pending_count;
   int bytes_checked;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int frames_sent = 0;

   always #5 clock = ~clock;

   telemetry_value_frame_stuffer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   tvfs_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .bytes_checked (bytes_checked)
   );

   always @(posedge clock) begin
      rsp_tready  <= ($urandom_range(0, 99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      logic [7:0] reserved [4];
      reserved = '{SEP_BYTE, ESC_SEP, FLAG_BYTE, ESC_FLAG};
      if ($urandom_range(0, 3) == 0) begin
         return reserved[$urandom_range(0, 3)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_value(input logic [7:0] value_id, input logic [15:0] value_word,
                             input logic high_first);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value_word, value_id};
      req_tuser  <= high_first;
      do begin
         @(posedge clock);
      end while (!req_tready);
      frames_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int idle_plan [4];
      int stall_plan [4];
      idle_plan  = '{0, 52, 0, 30};
      stall_plan = '{0, 0, 52, 30};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value(8'h00, 16'h0000, 1'b0);
      send_value(8'hFF, 16'hFFFF, 1'b1);
      send_value(8'h5E, 16'h1234, 1'b0);
      send_value(8'h5D, 16'h1234, 1'b1);
      send_value(8'h7E, 16'h0000, 1'b0);
      send_value(8'h7D, 16'hFFFF, 1'b1);
      send_value(8'h01, 16'h005E, 1'b0);
      send_value(8'h02, 16'h5D00, 1'b1);
      send_value(8'h03, 16'h7E7D, 1'b0);
      send_value(8'h04, 16'h7D7E, 1'b1);
      send_value(8'h5E, 16'h5E5D, 1'b0);
      send_value(8'h7E, 16'h7E7E, 1'b1);
      send_value(8'hA5, 16'h5A5A, 1'b0);
      send_value(8'h7D, 16'h5D5E, 1'b1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  <= idle_plan[ph];
         stall_pct <= stall_plan[ph];
         for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
            if (k == RANDOM_ITEMS / 8) begin
               drain();
            end
            send_value(pick_byte(), {pick_byte(), pick_byte()}, 1'($urandom_range(0, 1)));
         end
         drain();
      end

      stall_pct <= 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d telemetry frames, escape-heavy values included, across four pacing",
               frames_sent);
      $display("phases with sender gaps and receiver stalls; %0d line bytes compared.",
               bytes_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
